// ----- src/imuf_pkg.sv -----
// Shared types and constants for the IMU lowpass/lead block.
// Holds field widths, coefficient constants, axis and register codes, job types.
// No dependencies.
package imuf_pkg;

  // Field and datapath widths
  localparam int AXIS_W      = 4;
  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = 22;
  localparam int X_W         = 17;   // sample after optional negation
  localparam int HIST_W      = 48;
  localparam int HALF_W      = 24;   // history word is split in two halves
  localparam int COEF_W      = 33;
  localparam int MUL_A_W     = 25;
  localparam int PROD_W      = MUL_A_W + COEF_W;
  localparam int ACC_W       = 62;
  localparam int GUARD_BITS  = 8;
  localparam int LO_SHIFT    = 22;
  localparam int HI_SHIFT    = HALF_W - LO_SHIFT;
  localparam int LEAD_SUM_W  = 51;
  localparam int DC_W        = 37;   // clamped magnetometer difference
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int MAC_STEPS   = 7;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MAG_AXES    = 3;
  localparam int MAG_SEL_W   = 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_ACCEL_X = 4'd0;
  localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = 4'd2;
  localparam logic [AXIS_W-1:0] AXIS_GYRO_X  = 4'd3;
  localparam logic [AXIS_W-1:0] AXIS_GYRO_Z  = 4'd5;
  localparam logic [AXIS_W-1:0] AXIS_MAG_X   = 4'd6;
  localparam logic [AXIS_W-1:0] AXIS_MAG_Z   = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_GAIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_GAIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_GAIN_Z   = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd16384;

  // Filter coefficients, Q2.30
  localparam logic signed [COEF_W-1:0] COEF_A1  = 33'sd3086350582;
  localparam logic signed [COEF_W-1:0] COEF_NA2 = -33'sd2959813672;
  localparam logic signed [COEF_W-1:0] COEF_A3  = 33'sd946954914;
  localparam logic signed [COEF_W-1:0] COEF_B0  = 33'sd250000;

  // Coefficient for history tap 0..2; the input tap otherwise
  function automatic logic signed [COEF_W-1:0] coef_for(input logic [1:0] sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      2'd0:    c = COEF_A1;
      2'd1:    c = COEF_NA2;
      2'd2:    c = COEF_A3;
      default: c = COEF_B0;
    endcase
    return c;
  endfunction

  // One classified item
  typedef struct packed {
    logic [AXIS_W-1:0]         axis;
    logic                      live;     // axis has a channel
    logic                      mag;      // magnetometer axis
    logic [MAG_SEL_W-1:0]      mag_sel;
    logic signed [X_W-1:0]     x;
  } job_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

// ----- src/imuf_if.sv -----
// Stream interfaces for the IMU lowpass/lead block: sample input and result output.
// Depends on imuf_pkg for field widths.
interface imuf_in_if;
  import imuf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [AXIS_W-1:0]          axis;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output axis, output sample, input ready);
  modport sink   (input valid, input axis, input sample, output ready);
endinterface

interface imuf_out_if;
  import imuf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis_out;
  logic signed [OUT_W-1:0] smoothed;

  modport source (output valid, output axis_out, output smoothed, input ready);
  modport sink   (input valid, input axis_out, input smoothed, output ready);
endinterface

// ----- src/imuf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imuf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/imuf_queue.sv -----
// Two-entry job queue between the front end and the filter engine.
// Depends on imuf_pkg for job_t and head_t.
module imuf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  imuf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output imuf_pkg::head_t head
);
  import imuf_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];

endmodule

// ----- src/imuf_front.sv -----
// Front end: takes samples, classifies the axis (channel, sign flip, magnetometer)
// and queues the job. Depends on imuf_pkg, imuf_if and imuf_queue.
module imuf_front #(
  parameter int CHANNELS = 9
) (
  input  logic            clk,
  input  logic            rst,
  imuf_in_if.sink         sample_ch,
  input  logic            pop,
  output imuf_pkg::head_t head
);
  import imuf_pkg::*;

  localparam logic [AXIS_W:0] CH_LIMIT = (AXIS_W + 1)'(CHANNELS);

  job_t              job;
  logic              full;
  logic              flip;
  logic              push;
  logic [AXIS_W-1:0] mag_rel;
  logic signed [X_W-1:0] x_raw;

  // Classify the incoming sample
  always_comb begin
    flip = (sample_ch.axis == AXIS_ACCEL_X) || (sample_ch.axis == AXIS_ACCEL_Z) ||
           (sample_ch.axis == AXIS_GYRO_X)  || (sample_ch.axis == AXIS_GYRO_Z);
    x_raw   = {sample_ch.sample[SAMPLE_W-1], sample_ch.sample};
    mag_rel = sample_ch.axis - AXIS_MAG_X;

    job.axis    = sample_ch.axis;
    job.live    = ({1'b0, sample_ch.axis} < CH_LIMIT);
    job.mag     = (sample_ch.axis >= AXIS_MAG_X) && (sample_ch.axis <= AXIS_MAG_Z);
    job.mag_sel = job.mag ? mag_rel[MAG_SEL_W-1:0] : '0;
    job.x       = flip ? -x_raw : x_raw;
  end

  assign sample_ch.ready = !full;
  assign push            = sample_ch.valid && !full;

  imuf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

endmodule

// ----- src/imuf_back.sv -----
// Filter engine: per-axis history RAM, shared 25x33 MAC for the IIR taps,
// lead output, magnetometer correction and the output register.
// Depends on imuf_pkg, imuf_if and imuf_ram.
module imuf_back #(
  parameter int CHANNELS          = 9,
  parameter int HISTORY_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  imuf_pkg::head_t                 head,
  output logic                            pop,
  input  logic                            cfg_wen,
  input  logic [imuf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imuf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  imuf_out_if.source                      result_ch
);
  import imuf_pkg::*;

  localparam int AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W      = 3 * HIST_W;
  localparam int B0_LSH     = (HISTORY_FRAC_BITS + GUARD_BITS >= 30) ?
                              HISTORY_FRAC_BITS + GUARD_BITS - 30 : 0;
  localparam int B0_RSH     = (HISTORY_FRAC_BITS + GUARD_BITS >= 30) ?
                              0 : 30 - HISTORY_FRAC_BITS - GUARD_BITS;
  localparam int LEAD_SHIFT = HISTORY_FRAC_BITS - 4;
  localparam int LEAD_W     = 56 - HISTORY_FRAC_BITS;
  localparam int D_W        = LEAD_W + 1;
  localparam int DX_W       = (D_W > DC_W + 1) ? D_W : DC_W + 1;
  localparam int GP_W       = DC_W + GAIN_W + 1;
  localparam logic [2:0] LAST_STEP = 3'(MAC_STEPS - 1);

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (GUARD_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_HI =
    {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_LO =
    {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
  localparam logic signed [LEAD_SUM_W-1:0] LEAD_HALF =
    {{(LEAD_SUM_W-1){1'b0}}, 1'b1} << (HISTORY_FRAC_BITS - 5);
  localparam logic signed [LEAD_W-1:0] LEAD_HI =
    {{(LEAD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [LEAD_W-1:0] LEAD_LO =
    {{(LEAD_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
  localparam logic signed [DX_W-1:0] DC_HI =
    {{(DX_W-DC_W+1){1'b0}}, {(DC_W-1){1'b1}}};
  localparam logic signed [DX_W-1:0] DC_LO =
    {{(DX_W-DC_W+1){1'b1}}, {(DC_W-1){1'b0}}};
  localparam logic signed [GP_W-1:0] GP_HALF =
    {{(GP_W-1){1'b0}}, 1'b1} << (GAIN_FRAC - 1);
  localparam logic signed [GP_W-1:0] GP_HI =
    {{(GP_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [GP_W-1:0] GP_LO =
    {{(GP_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ROUND, S_LEAD, S_CORR, S_GAIN, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {K_LO, K_HI, K_B0} kind_t;

  state_t                     state;
  job_t                       job;
  logic [2:0]                 step;
  logic                       row_ok;
  logic [CHANNELS-1:0]        row_valid;
  logic signed [PROD_W-1:0]   p;
  kind_t                      p_kind;
  logic signed [ACC_W-1:0]    acc;
  logic signed [HIST_W-1:0]   y;
  logic signed [LEAD_W-1:0]   lead_r;
  logic signed [DC_W-1:0]     dc;
  logic signed [GP_W-1:0]     gp;
  logic signed [OUT_W-1:0]    res;
  logic [SAMPLE_W-1:0]        mag_offset [MAG_AXES];
  logic [GAIN_W-1:0]          mag_gain [MAG_AXES];
  logic                       out_valid;
  logic                       out_load;
  logic [AXIS_W-1:0]          out_axis;
  logic signed [OUT_W-1:0]    out_smoothed;

  logic                       rd_en;
  logic                       wr_en;
  logic [ROW_W-1:0]           rd_data;
  logic [ROW_W-1:0]           wr_data;
  logic signed [HIST_W-1:0]   h0, h1, h2, h_pick;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  kind_t                      kind;
  logic signed [ACC_W-1:0]    p_ext, term;
  logic signed [ACC_W-1:0]    acc_rnd, y_wide;
  logic signed [HIST_W-1:0]   y_next;
  logic signed [LEAD_SUM_W-1:0] y_x, h1_x, lead_sum, lead_shr;
  logic signed [LEAD_W-1:0]   lead_next;
  logic signed [OUT_W-1:0]    lead_sat;
  logic signed [SAMPLE_W-1:0] off;
  logic signed [DX_W-1:0]     d_x;
  logic signed [DC_W-1:0]     dc_next;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [GP_W-1:0]     gp_rnd, gp_shr;
  logic signed [OUT_W-1:0]    gain_sat;

  // History RAM: one row per axis holds y[n-1], y[n-2], y[n-3]
  assign pop     = (state == S_IDLE) && head.valid;
  assign rd_en   = pop && head.job.live;
  assign wr_en   = (state == S_ROUND);
  assign wr_data = {h1, h0, y_next};

  imuf_ram #(.WIDTH(ROW_W), .DEPTH(CHANNELS)) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (job.axis[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head.job.axis[AW-1:0]),
    .rd_data (rd_data)
  );

  // A row never written reads as zero
  assign h0 = row_ok ? $signed(rd_data[HIST_W-1:0])          : '0;
  assign h1 = row_ok ? $signed(rd_data[2*HIST_W-1:HIST_W])   : '0;
  assign h2 = row_ok ? $signed(rd_data[3*HIST_W-1:2*HIST_W]) : '0;

  // Select MAC operands: low and high half of each tap, then the input tap
  always_comb begin
    case (step[2:1])
      2'd0:    h_pick = h0;
      2'd1:    h_pick = h1;
      default: h_pick = h2;
    endcase
    mul_b = coef_for(step[2:1]);
    if (step == LAST_STEP) begin
      mul_a = {{(MUL_A_W-X_W){job.x[X_W-1]}}, job.x};
      kind  = K_B0;
    end else if (!step[0]) begin
      mul_a = {1'b0, h_pick[HALF_W-1:0]};
      kind  = K_LO;
    end else begin
      mul_a = {h_pick[HIST_W-1], h_pick[HIST_W-1:HALF_W]};
      kind  = K_HI;
    end
  end

  // Scale the registered product to the accumulator's fraction
  always_comb begin
    p_ext = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    case (p_kind)
      K_LO:    term = p_ext >>> LO_SHIFT;
      K_HI:    term = p_ext <<< HI_SHIFT;
      default: term = (p_ext <<< B0_LSH) >>> B0_RSH;
    endcase
  end

  // Round the sum to history precision and saturate
  always_comb begin
    acc_rnd = acc + ACC_HALF;
    y_wide  = acc_rnd >>> GUARD_BITS;
    if (y_wide > Y_HI) begin
      y_next = Y_HI[HIST_W-1:0];
    end else if (y_wide < Y_LO) begin
      y_next = Y_LO[HIST_W-1:0];
    end else begin
      y_next = y_wide[HIST_W-1:0];
    end
  end

  // Lead value 2*y[n] - y[n-2], rounded to 4 fraction bits
  always_comb begin
    y_x       = {{(LEAD_SUM_W-HIST_W){y[HIST_W-1]}}, y};
    h1_x      = {{(LEAD_SUM_W-HIST_W){h1[HIST_W-1]}}, h1};
    lead_sum  = (y_x <<< 1) - h1_x + LEAD_HALF;
    lead_shr  = lead_sum >>> LEAD_SHIFT;
    lead_next = lead_shr[LEAD_W-1:0];
    if (lead_r > LEAD_HI) begin
      lead_sat = LEAD_HI[OUT_W-1:0];
    end else if (lead_r < LEAD_LO) begin
      lead_sat = LEAD_LO[OUT_W-1:0];
    end else begin
      lead_sat = lead_r[OUT_W-1:0];
    end
  end

  // Hard-iron offset; clamp far enough out that any nonzero gain saturates
  always_comb begin
    off = $signed(mag_offset[job.mag_sel]);
    d_x = {{(DX_W-LEAD_W){lead_r[LEAD_W-1]}}, lead_r}
        - ({{(DX_W-SAMPLE_W){off[SAMPLE_W-1]}}, off} <<< 4);
    if (d_x > DC_HI) begin
      dc_next = DC_HI[DC_W-1:0];
    end else if (d_x < DC_LO) begin
      dc_next = DC_LO[DC_W-1:0];
    end else begin
      dc_next = d_x[DC_W-1:0];
    end
    gain_s = {1'b0, mag_gain[job.mag_sel]};
  end

  // Soft-iron gain rounding and output saturation
  always_comb begin
    gp_rnd = gp + GP_HALF;
    gp_shr = gp_rnd >>> GAIN_FRAC;
    if (gp_shr > GP_HI) begin
      gain_sat = GP_HI[OUT_W-1:0];
    end else if (gp_shr < GP_LO) begin
      gain_sat = GP_LO[OUT_W-1:0];
    end else begin
      gain_sat = gp_shr[OUT_W-1:0];
    end
  end

  // Load the output register when it is empty or being taken
  assign out_load = (state == S_DONE) && (!out_valid || result_ch.ready);

  // Sequencer, datapath registers, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      row_valid  <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAG_AXES; i++) begin
        mag_offset[i] <= '0;
        mag_gain[i]   <= GAIN_ONE;
      end
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_MAG_OFFSET_X: mag_offset[0] <= cfg_wdata;
          REG_MAG_OFFSET_Y: mag_offset[1] <= cfg_wdata;
          REG_MAG_OFFSET_Z: mag_offset[2] <= cfg_wdata;
          REG_MAG_GAIN_X:   mag_gain[0]   <= cfg_wdata;
          REG_MAG_GAIN_Y:   mag_gain[1]   <= cfg_wdata;
          REG_MAG_GAIN_Z:   mag_gain[2]   <= cfg_wdata;
          default: ;
        endcase
      end

      // Load a new result, or drop the current one once it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (head.valid) begin
            job    <= head.job;
            row_ok <= head.job.live && row_valid[head.job.axis[AW-1:0]];
            acc    <= '0;
            step   <= '0;
            if (head.job.live) begin
              state <= S_MAC;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_MAC: begin
          p      <= mul_a * mul_b;
          p_kind <= kind;
          if (step != '0) begin
            acc <= acc + term;
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          acc   <= acc + term;
          state <= S_ROUND;
        end
        S_ROUND: begin
          y                           <= y_next;
          row_valid[job.axis[AW-1:0]] <= 1'b1;
          state                       <= S_LEAD;
        end
        S_LEAD: begin
          lead_r <= lead_next;
          state  <= S_CORR;
        end
        S_CORR: begin
          if (job.mag) begin
            dc    <= dc_next;
            state <= S_GAIN;
          end else begin
            res   <= lead_sat;
            state <= S_DONE;
          end
        end
        S_GAIN: begin
          gp    <= dc * gain_s;
          state <= S_FIN;
        end
        S_FIN: begin
          res   <= gain_sat;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_axis     <= job.axis;
            out_smoothed <= res;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_ch.valid    = out_valid;
  assign result_ch.axis_out = out_axis;
  assign result_ch.smoothed = out_smoothed;

endmodule

// ----- src/imu_axis_iir_lowpass_lead.sv -----
// Nine-axis IMU smoother: each sample (signed 16-bit, with its axis number) runs
// through a third-order all-pole lowpass with its own history per axis, and the
// result is the lead value 2*y[n]-y[n-2] in counts with 4 fraction bits, saturated
// to 22 bits; accel and gyro X and Z are negated on entry, and magnetometer axes get
// the hard-iron offset removed and the soft-iron gain applied. Axis numbers with no
// channel return 0 and leave the history alone. A two-entry queue takes samples
// while the engine works. The engine runs one sample at a time through a single
// 25x33 multiplier that makes seven passes (two per history tap, one for the
// input); magnetometer axes also pass through the offset and gain steps, and an
// axis with no channel skips straight to the output. History reads as zero after
// reset through one valid bit per axis, with no clearing pass. Write the offset and
// gain registers only while no sample is in flight.
module imu_axis_iir_lowpass_lead #(
  parameter int CHANNELS          = 9,
  parameter int HISTORY_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  imuf_in_if.sink                         sample_ch,
  imuf_out_if.source                      result_ch,
  input  logic                            cfg_wen,
  input  logic [imuf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imuf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import imuf_pkg::*;

  head_t head;
  logic  pop;

  // Accept and classify
  imuf_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .pop       (pop),
    .head      (head)
  );

  // Filter and correct
  imuf_back #(
    .CHANNELS          (CHANNELS),
    .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result_ch (result_ch)
  );

endmodule

// ----- src/imuf_checker.sv -----
// Port-level checks for the IMU lowpass/lead block, bound to its top level.
// Depends on imuf_pkg for field widths.
module imuf_checker #(
  parameter int CHANNELS = 9
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [imuf_pkg::AXIS_W-1:0]         out_axis,
  input logic signed [imuf_pkg::OUT_W-1:0]   out_smoothed
);
  import imuf_pkg::*;

  localparam logic [AXIS_W:0] CH_LIMIT = (AXIS_W + 1)'(CHANNELS);

  logic       in_fire;
  logic       out_fire;
  logic [3:0] outstanding;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Track samples taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(in_fire) - 4'(out_fire);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_axis) && $stable(out_smoothed))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> outstanding != '0)
    else $error("result transfer with no sample outstanding");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, out_axis} >= CH_LIMIT) |-> out_smoothed == '0)
    else $error("nonzero result for an axis with no channel");

endmodule

bind imu_axis_iir_lowpass_lead imuf_checker #(.CHANNELS(CHANNELS)) u_imuf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_ch.valid),
  .in_ready     (sample_ch.ready),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .out_axis     (result_ch.axis_out),
  .out_smoothed (result_ch.smoothed)
);
